FILE: hdl/psrb_pkg.sv
// Shared constants, codes and control structs for the pipe slot ring buffers.
package psrb_pkg;

  localparam int SLOTS        = 8;
  localparam int BUFFER_BYTES = 512;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PTR_W  = $clog2(BUFFER_BYTES);
  localparam int FILL_W = $clog2(BUFFER_BYTES + 1);
  localparam int ADDR_W = $clog2(SLOTS * BUFFER_BYTES);
  localparam int DEPTH  = SLOTS * BUFFER_BYTES;

  localparam logic [15:0] BASE_RESET = 16'd100;

  // request kinds
  localparam logic [2:0] KIND_CREATE   = 3'd0;
  localparam logic [2:0] KIND_READ     = 3'd1;
  localparam logic [2:0] KIND_WRITE    = 3'd2;
  localparam logic [2:0] KIND_CLOSE    = 3'd3;
  localparam logic [2:0] KIND_CLASSIFY = 3'd4;

  // result status codes
  localparam logic [2:0] STS_OK     = 3'd0;
  localparam logic [2:0] STS_EOS    = 3'd1;
  localparam logic [2:0] STS_BLOCK  = 3'd2;
  localparam logic [2:0] STS_BADFD  = 3'd3;
  localparam logic [2:0] STS_BROKEN = 3'd4;
  localparam logic [2:0] STS_NOSLOT = 3'd5;

  // classify answers
  localparam logic [1:0] END_NONE  = 2'd0;
  localparam logic [1:0] END_READ  = 2'd1;
  localparam logic [1:0] END_WRITE = 2'd2;

  localparam logic [1:0] ENDS_BOTH = 2'd2;

  typedef struct packed {
    logic load;        // latch the input transaction
    logic exec;        // decide and update slot state
    logic rd_capture;  // take byte from the store
    logic out_load;    // move result to the output register
  } dp_cmd_t;

  typedef struct packed {
    logic rd_go;       // current request reads the byte store
  } dp_sts_t;

endpackage

FILE: hdl/pipe_slot_ring_buffers.sv
// Top level of the pipe slot ring buffers: a pool of byte FIFO pipes.
//
// Input channel (in_*): one request per transaction. in_tuser carries the
// request kind (create, read byte, write byte, close, classify); in_tdata
// carries the descriptor and the byte to write.
// Result channel (out_*): exactly one result per request, in request order:
// status in out_tuser, and the read byte, the two new descriptors and the
// classify answer in out_tdata.
// Configuration: cfg_wr_en/cfg_wr_data set the descriptor base (reset 100);
// write it only while no request is in flight.
// Timing: a request is accepted, executed in the next cycle, and its result
// is then loaded into the output register (a read that returns a byte first
// waits on the byte store's registered read port). No new request is taken
// until the previous result has moved into the output register.
// Reset clears every slot to free and sets the descriptor base; the byte
// store is not cleared and needs no clearing pass.
// When the receiver stalls, the result waits in the output register and one
// more request is still accepted and executed; its result then waits inside
// until the output register frees.
module pipe_slot_ring_buffers (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,   // descriptor_base
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,      // [15:0] descriptor, [23:16] write_data
  input  logic [7:0]  in_tuser,      // [2:0] kind, [7:3] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,     // [7:0] read_data, [23:8] read_end,
                                     // [39:24] write_end, [41:40] end_type
  output logic [7:0]  out_tuser      // [2:0] status, [7:3] zero
);
  import psrb_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  psrb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  psrb_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_kind       (in_tuser[2:0]),
    .in_descriptor (in_tdata[15:0]),
    .in_write_data (in_tdata[23:16]),
    .cmd           (cmd),
    .sts           (sts),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser)
  );

endmodule

FILE: hdl/psrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module psrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/psrb_ctrl.sv
// Request sequencer: accept, execute, optional store read, hand off to output.
module psrb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  psrb_pkg::dp_sts_t sts,
  output psrb_pkg::dp_cmd_t cmd
);
  import psrb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_RDWAIT = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.rd_go ? S_RDWAIT : S_DONE;
      end
      S_RDWAIT: begin
        cmd.rd_capture = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_EXEC)
    else $error("accepted transaction did not start execution");

  a_rdwait_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RDWAIT |-> $past(state_r == S_EXEC) && $past(sts.rd_go))
    else $error("store read wait without a read issue");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_tvalid)
    else $error("result load did not raise out_tvalid");
`endif

endmodule

FILE: hdl/psrb_dp.sv
// Datapath: descriptor decode, per-slot pipe state, byte store and result registers.
module psrb_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data,
  input  logic [2:0]        in_kind,
  input  logic [15:0]       in_descriptor,
  input  logic [7:0]        in_write_data,
  input  psrb_pkg::dp_cmd_t cmd,
  output psrb_pkg::dp_sts_t sts,
  output logic [47:0]       out_tdata,
  output logic [7:0]        out_tuser
);
  import psrb_pkg::*;

  logic [15:0] base_r;

  // latched request
  logic [2:0]  kind_r;
  logic [15:0] fd_r;
  logic [7:0]  wd_r;

  // per-slot state
  logic              open_r    [SLOTS];
  logic [PTR_W-1:0]  head_r    [SLOTS];
  logic [PTR_W-1:0]  tail_r    [SLOTS];
  logic [FILL_W-1:0] fill_r    [SLOTS];
  logic              rclosed_r [SLOTS];
  logic              wclosed_r [SLOTS];
  logic [1:0]        ends_r    [SLOTS];

  // result being built, and output register
  logic [2:0]  res_status_r;
  logic [7:0]  res_rdata_r;
  logic [15:0] res_rend_r;
  logic [15:0] res_wend_r;
  logic [1:0]  res_etype_r;

  logic [2:0]  out_status_r;
  logic [7:0]  out_rdata_r;
  logic [15:0] out_rend_r;
  logic [15:0] out_wend_r;
  logic [1:0]  out_etype_r;

  // decode
  logic [16:0]       diff;
  logic [15:0]       off;
  logic [SLOT_W-1:0] s;
  logic              fd_ok;
  logic              is_w;

  logic              free_found;
  logic [SLOT_W-1:0] free_s;

  logic [2:0]  status_c;
  logic [15:0] rend_c;
  logic [15:0] wend_c;
  logic [1:0]  etype_c;
  logic        rd_go;
  logic        wr_go;
  logic        create_go;
  logic        close_go;
  logic [1:0]  ends_dec;

  logic [7:0]        ram_rdata;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;

  assign diff  = {1'b0, fd_r} - {1'b0, base_r};
  assign off   = diff[15:0];
  assign s     = off[SLOT_W:1];
  assign is_w  = off[0];
  assign fd_ok = !diff[16] && (off[15:1] < 15'(SLOTS)) && open_r[s];

  always_comb begin
    free_found = 1'b0;
    free_s     = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!open_r[i]) begin
        free_found = 1'b1;
        free_s     = SLOT_W'(i);
      end
    end
  end

  assign ends_dec = (ends_r[s] == 2'd0) ? 2'd0 : ends_r[s] - 2'd1;

  always_comb begin
    status_c  = STS_BADFD;
    rend_c    = '0;
    wend_c    = '0;
    etype_c   = END_NONE;
    rd_go     = 1'b0;
    wr_go     = 1'b0;
    create_go = 1'b0;
    close_go  = 1'b0;
    case (kind_r)
      KIND_CREATE: begin
        if (!free_found) begin
          status_c = STS_NOSLOT;
        end else begin
          create_go = 1'b1;
          status_c  = STS_OK;
          rend_c    = base_r + (16'(free_s) << 1);
          wend_c    = base_r + (16'(free_s) << 1) + 16'd1;
        end
      end
      KIND_CLASSIFY: begin
        status_c = STS_OK;
        etype_c  = !fd_ok ? END_NONE : (is_w ? END_WRITE : END_READ);
      end
      KIND_READ: begin
        if (fd_ok && !is_w && !rclosed_r[s]) begin
          if (fill_r[s] == '0) begin
            status_c = wclosed_r[s] ? STS_EOS : STS_BLOCK;
          end else begin
            rd_go    = 1'b1;
            status_c = STS_OK;
          end
        end
      end
      KIND_WRITE: begin
        if (fd_ok && is_w && !wclosed_r[s]) begin
          if (rclosed_r[s]) begin
            status_c = STS_BROKEN;
          end else if (fill_r[s] == FILL_W'(BUFFER_BYTES)) begin
            status_c = STS_BLOCK;
          end else begin
            wr_go    = 1'b1;
            status_c = STS_OK;
          end
        end
      end
      KIND_CLOSE: begin
        if (fd_ok && !(is_w ? wclosed_r[s] : rclosed_r[s])) begin
          close_go = 1'b1;
          status_c = STS_OK;
        end
      end
      default: begin
        status_c = STS_BADFD;
      end
    endcase
  end

  assign sts.rd_go = rd_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
    end else if (cfg_wr_en) begin
      base_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      fd_r   <= in_descriptor;
      wd_r   <= in_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        open_r[i]    <= 1'b0;
        head_r[i]    <= '0;
        tail_r[i]    <= '0;
        fill_r[i]    <= '0;
        rclosed_r[i] <= 1'b0;
        wclosed_r[i] <= 1'b0;
        ends_r[i]    <= '0;
      end
    end else if (cmd.exec) begin
      if (create_go) begin
        open_r[free_s]    <= 1'b1;
        head_r[free_s]    <= '0;
        tail_r[free_s]    <= '0;
        fill_r[free_s]    <= '0;
        rclosed_r[free_s] <= 1'b0;
        wclosed_r[free_s] <= 1'b0;
        ends_r[free_s]    <= ENDS_BOTH;
      end
      if (rd_go) begin
        head_r[s] <= (head_r[s] == PTR_W'(BUFFER_BYTES - 1)) ? '0 : head_r[s] + 1'b1;
        fill_r[s] <= fill_r[s] - 1'b1;
      end
      if (wr_go) begin
        tail_r[s] <= (tail_r[s] == PTR_W'(BUFFER_BYTES - 1)) ? '0 : tail_r[s] + 1'b1;
        fill_r[s] <= fill_r[s] + 1'b1;
      end
      if (close_go) begin
        if (ends_dec == 2'd0) begin
          // last end gone: slot returns to the pool
          open_r[s]    <= 1'b0;
          head_r[s]    <= '0;
          tail_r[s]    <= '0;
          fill_r[s]    <= '0;
          rclosed_r[s] <= 1'b0;
          wclosed_r[s] <= 1'b0;
          ends_r[s]    <= '0;
        end else begin
          ends_r[s] <= ends_dec;
          if (is_w) begin
            wclosed_r[s] <= 1'b1;
          end else begin
            rclosed_r[s] <= 1'b1;
          end
        end
      end
    end
  end

  assign ram_waddr = ADDR_W'(s) * ADDR_W'(BUFFER_BYTES) + ADDR_W'(tail_r[s]);
  assign ram_raddr = ADDR_W'(s) * ADDR_W'(BUFFER_BYTES) + ADDR_W'(head_r[s]);

  psrb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.exec && wr_go),
    .waddr (ram_waddr),
    .wdata (wd_r),
    .re    (cmd.exec && rd_go),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status_r <= status_c;
      res_rdata_r  <= '0;
      res_rend_r   <= rend_c;
      res_wend_r   <= wend_c;
      res_etype_r  <= etype_c;
    end else if (cmd.rd_capture) begin
      res_rdata_r <= ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_rdata_r  <= res_rdata_r;
      out_rend_r   <= res_rend_r;
      out_wend_r   <= res_wend_r;
      out_etype_r  <= res_etype_r;
    end
  end

  assign out_tdata = {6'd0, out_etype_r, out_wend_r, out_rend_r, out_rdata_r};
  assign out_tuser = {5'd0, out_status_r};

`ifndef SYNTHESIS
  logic fill_ok;
  logic ends_ok;

  always_comb begin
    fill_ok = 1'b1;
    ends_ok = 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      if (fill_r[i] > FILL_W'(BUFFER_BYTES)) begin
        fill_ok = 1'b0;
      end
      if (!open_r[i] && ends_r[i] != 2'd0) begin
        ends_ok = 1'b0;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n) fill_ok)
    else $error("slot fill count beyond buffer size");

  a_free_slot_idle: assert property (@(posedge clk) disable iff (!rst_n) ends_ok)
    else $error("free slot still counts open ends");
`endif

endmodule

FILE: sim/psrb_pipe_checker.sv
// Channel monitor, pipe pool predictor and result scoreboard for pipe_slot_ring_buffers.
`timescale 1ns / 1ps

module psrb_pipe_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic [7:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic [7:0]  out_tuser,
  output int          errors,
  output int          pending,
  output int          checked,
  output logic [5:0]  status_seen
);
  import psrb_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  rd_byte;
    logic [15:0] rd_fd;
    logic [15:0] wr_fd;
    logic [1:0]  end_kind;
  } pipe_result_t;

  // shadow of the pipe pool
  logic [15:0]       fd_base;
  bit                slot_busy  [SLOTS];
  logic [PTR_W-1:0]  rd_ptr     [SLOTS];
  logic [PTR_W-1:0]  wr_ptr     [SLOTS];
  logic [FILL_W-1:0] level      [SLOTS];
  bit                rd_shut    [SLOTS];
  bit                wr_shut    [SLOTS];
  logic [1:0]        live_ends  [SLOTS];
  logic [7:0]        byte_mem   [SLOTS][BUFFER_BYTES];

  pipe_result_t expected_q[$];

  function automatic void free_slot(int s);
    slot_busy[s] = 1'b0;
    rd_ptr[s]    = '0;
    wr_ptr[s]    = '0;
    level[s]     = '0;
    rd_shut[s]   = 1'b0;
    wr_shut[s]   = 1'b0;
    live_ends[s] = '0;
  endfunction

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    return (int'(p) == BUFFER_BYTES - 1) ? '0 : p + 1'b1;
  endfunction

  // Apply one request to the shadow pool and return the result it must give.
  function automatic pipe_result_t service_request(logic [2:0] kind, logic [15:0] fd,
                                                   logic [7:0] wd);
    pipe_result_t r;
    logic [16:0]  off;
    int           s;
    int           i;
    bit           wr_end;
    r        = '0;
    r.status = STS_BADFD;
    s        = -1;
    wr_end   = 1'b0;
    if (fd >= fd_base) begin
      off = {1'b0, fd} - {1'b0, fd_base};
      if ((off >> 1) < SLOTS && slot_busy[off >> 1]) begin
        s      = int'(off >> 1);
        wr_end = off[0];
      end
    end
    case (kind)
      KIND_CREATE: begin
        s = -1;
        for (i = SLOTS - 1; i >= 0; i--)
          if (!slot_busy[i]) s = i;
        if (s < 0) begin
          r.status = STS_NOSLOT;
        end else begin
          free_slot(s);
          slot_busy[s] = 1'b1;
          live_ends[s] = ENDS_BOTH;
          r.rd_fd  = fd_base + 16'(2 * s);
          r.wr_fd  = fd_base + 16'(2 * s + 1);
          r.status = STS_OK;
        end
      end
      KIND_CLASSIFY: begin
        r.status   = STS_OK;
        r.end_kind = (s < 0) ? END_NONE : (wr_end ? END_WRITE : END_READ);
      end
      KIND_READ: begin
        if (s < 0 || wr_end || rd_shut[s]) begin
          r.status = STS_BADFD;
        end else if (level[s] == 0) begin
          r.status = wr_shut[s] ? STS_EOS : STS_BLOCK;
        end else begin
          r.rd_byte = byte_mem[s][rd_ptr[s]];
          rd_ptr[s] = bump(rd_ptr[s]);
          level[s]  = level[s] - 1'b1;
          r.status  = STS_OK;
        end
      end
      KIND_WRITE: begin
        if (s < 0 || !wr_end || wr_shut[s]) begin
          r.status = STS_BADFD;
        end else if (rd_shut[s]) begin
          r.status = STS_BROKEN;
        end else if (int'(level[s]) >= BUFFER_BYTES) begin
          r.status = STS_BLOCK;
        end else begin
          byte_mem[s][wr_ptr[s]] = wd;
          wr_ptr[s] = bump(wr_ptr[s]);
          level[s]  = level[s] + 1'b1;
          r.status  = STS_OK;
        end
      end
      KIND_CLOSE: begin
        if (s < 0 || (wr_end ? wr_shut[s] : rd_shut[s])) begin
          r.status = STS_BADFD;
        end else begin
          if (wr_end) wr_shut[s] = 1'b1;
          else rd_shut[s] = 1'b1;
          if (live_ends[s] != 0) live_ends[s] = live_ends[s] - 1'b1;
          if (live_ends[s] == 0) free_slot(s);
          r.status = STS_OK;
        end
      end
      default: r.status = STS_BADFD;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    pipe_result_t want;
    pipe_result_t got;
    if (!rst_n) begin
      fd_base     = BASE_RESET;
      for (int i = 0; i < SLOTS; i++) free_slot(i);
      expected_q.delete();
      errors      = 0;
      checked     = 0;
      status_seen = '0;
    end else begin
      if (cfg_wr_en) fd_base = cfg_wr_data;
      // a result never leaves in the cycle its request is accepted, so compare first
      if (out_tvalid && out_tready) begin
        got.status   = out_tuser[2:0];
        got.rd_byte  = out_tdata[7:0];
        got.rd_fd    = out_tdata[23:8];
        got.wr_fd    = out_tdata[39:24];
        got.end_kind = out_tdata[41:40];
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("[%0t] result transaction with nothing outstanding: status %0d",
                     $realtime, got.status);
        end else begin
          want = expected_q.pop_front();
          checked++;
          status_seen[want.status] = 1'b1;
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"[%0t] mismatch: status %0d/%0d byte %02h/%02h rd_fd %04h/%04h",
                        " wr_fd %04h/%04h end %0d/%0d (expected/actual)"},
                       $realtime, want.status, got.status, want.rd_byte, got.rd_byte,
                       want.rd_fd, got.rd_fd, want.wr_fd, got.wr_fd,
                       want.end_kind, got.end_kind);
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_q.push_back(service_request(in_tuser[2:0], in_tdata[15:0],
                                             in_tdata[23:16]));
    end
    pending = expected_q.size();
  end

endmodule

FILE: sim/tb_top.sv
// Stimulus, flow control and verdict for pipe_slot_ring_buffers.
`timescale 1ns / 1ps

module tb_top;
  import psrb_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD   = 80;
  localparam int PHASE_ITEMS = 95;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata    = '0;
  logic [7:0]  in_tuser    = '0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [47:0] out_tdata;
  logic [7:0]  out_tuser;

  int          errors;
  int          pending;
  int          checked;
  logic [5:0]  status_seen;

  logic [15:0] cur_base    = BASE_RESET;
  bit          no_idle     = 1'b0;
  bit          hold_req    = 1'b0;
  int          items_sent  = 0;
  int          base_writes = 0;
  int          cycle_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  pipe_slot_ring_buffers dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  psrb_pipe_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked),
    .status_seen(status_seen)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int gap;
    while (!rst_n) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // one request transaction; leaves in_tvalid high for back-to-back use
  task automatic send_req(logic [2:0] kind, logic [15:0] fd, logic [7:0] wd);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {wd, fd};
    in_tuser  <= {5'd0, kind};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic set_base(logic [15:0] value);
    drain_results();
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    cur_base     = value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    base_writes++;
  endtask

  // mostly requests on the right end of a slot in the pool, some noise
  task automatic random_req();
    int          pick;
    int          slot_i;
    logic [2:0]  kind;
    logic [15:0] fd;
    bit          end_bit;
    pick = $urandom_range(0, 99);
    if (pick < 10)      kind = KIND_CREATE;
    else if (pick < 40) kind = KIND_READ;
    else if (pick < 72) kind = KIND_WRITE;
    else if (pick < 82) kind = KIND_CLOSE;
    else if (pick < 95) kind = KIND_CLASSIFY;
    else                kind = 3'($urandom_range(5, 7));
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      slot_i = $urandom_range(0, SLOTS - 1);
      if (kind == KIND_READ)       end_bit = 1'b0;
      else if (kind == KIND_WRITE) end_bit = 1'b1;
      else                         end_bit = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) end_bit = !end_bit;
      fd = cur_base + 16'(2 * slot_i) + 16'(end_bit);
    end else if (pick < 90) begin
      fd = cur_base + 16'(2 * SLOTS) + 16'($urandom_range(0, 1));
    end else if (pick < 95 || cur_base == 0) begin
      fd = 16'($urandom);
    end else begin
      fd = 16'($urandom_range(0, cur_base - 1));
    end
    send_req(kind, fd, 8'($urandom));
  endtask

  initial begin : stimulus
    logic [15:0] phase_base [4];
    phase_base[0] = 16'd0;
    phase_base[1] = 16'h7FFF;
    phase_base[2] = 16'($urandom_range(0, 65408));
    phase_base[3] = BASE_RESET;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: pool exhaustion, wrong ends, eos, broken pipe, unknown kinds
    send_req(KIND_CLASSIFY, 16'd100, 8'h00);
    send_req(KIND_READ, 16'd99, 8'h00);
    repeat (SLOTS) send_req(KIND_CREATE, 16'($urandom), 8'($urandom));
    send_req(KIND_CREATE, 16'hFFFF, 8'hFF);
    send_req(KIND_WRITE, 16'd101, 8'hFF);
    send_req(KIND_WRITE, 16'd101, 8'h00);
    send_req(KIND_WRITE, 16'd100, 8'h5A);
    send_req(KIND_READ, 16'd101, 8'h00);
    send_req(KIND_READ, 16'd100, 8'h00);
    send_req(KIND_READ, 16'd100, 8'h00);
    send_req(KIND_READ, 16'd100, 8'h00);
    send_req(KIND_CLASSIFY, 16'd101, 8'h00);
    send_req(KIND_CLASSIFY, 16'd116, 8'h00);
    send_req(KIND_CLOSE, 16'd101, 8'h00);
    send_req(KIND_READ, 16'd100, 8'h00);
    send_req(KIND_CLOSE, 16'd101, 8'h00);
    send_req(KIND_CLOSE, 16'd102, 8'h00);
    send_req(KIND_WRITE, 16'd103, 8'hA5);
    send_req(KIND_CLASSIFY, 16'd102, 8'h00);
    send_req(KIND_CLOSE, 16'd100, 8'h00);
    send_req(KIND_CLASSIFY, 16'd100, 8'h00);
    send_req(3'd7, 16'hFFFF, 8'hFF);
    send_req(3'd5, 16'd0, 8'h00);

    // one pipe at the top base: bytes through, end of stream, both ends closed
    set_base(16'd65408);
    send_req(KIND_CREATE, 16'd0, 8'h00);
    repeat (8) begin
      send_req(KIND_WRITE, cur_base + 16'd1, 8'($urandom));
      send_req(KIND_READ, cur_base, 8'h00);
    end
    send_req(KIND_CLOSE, cur_base + 16'd1, 8'h00);
    send_req(KIND_READ, cur_base, 8'h00);
    send_req(KIND_CLOSE, cur_base, 8'h00);

    for (int ph = 0; ph < 4; ph++) begin
      set_base(phase_base[ph]);
      if (ph == 0) begin
        // receiver stalls long while requests keep coming back to back
        hold_req = 1'b1;
        no_idle  = 1'b1;
        repeat (30) random_req();
        no_idle  = 1'b0;
      end
      if (ph == 2) begin
        no_idle = 1'b1;
        repeat (PHASE_ITEMS / 2) random_req();
        no_idle = 1'b0;
        repeat (PHASE_ITEMS - PHASE_ITEMS / 2) random_req();
      end else begin
        repeat (PHASE_ITEMS) random_req();
      end
    end

    drain_results();
    repeat (8) @(negedge clk);

    $display("Run covered %0d requests and %0d checked results over %0d base settings.",
             items_sent, checked, base_writes);
    $display("Status codes returned (bit per code, code 0 lowest): %06b", status_seen);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/psrb_pkg.sv
hdl/psrb_ram.sv
hdl/psrb_ctrl.sv
hdl/psrb_dp.sv
hdl/pipe_slot_ring_buffers.sv
sim/psrb_pipe_checker.sv
sim/tb_top.sv
